/* sv/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and crc functions of the sample frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam logic [15:0] SFB_CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] SFB_CRC_POLY   = 16'h1021;
    localparam logic [15:0] SFB_CRC_TOPBIT = 16'h8000;
    localparam logic [7:0]  SFB_PRE_FIRST  = 8'hAA;
    localparam logic [7:0]  SFB_PRE_SECOND = 8'h55;

    localparam logic SFB_REQ_START  = 1'b0;
    localparam logic SFB_REQ_SAMPLE = 1'b1;

    localparam int SFB_Q_DEPTH = 4;

    // one unit of work for the serializer
    typedef struct packed {
        logic        is_hdr;
        logic        with_crc;
        logic [15:0] data;
        logic [15:0] crc;
    } t_job;

    function automatic logic [15:0] sfb_crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((r & SFB_CRC_TOPBIT) != 16'h0000) begin
                r = {r[14:0], 1'b0} ^ SFB_CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // low byte first, then high byte
    function automatic logic [15:0] sfb_crc_word(input logic [15:0] c, input logic [15:0] w);
        return sfb_crc_byte(sfb_crc_byte(c, w[7:0]), w[15:8]);
    endfunction

endpackage

/* sv/sfb_front.sv */
// ----------------------------------------------------------------------------
// sfb_front
// Accepts requests, tracks the open frame and the running crc, and queues
// one serializer job per request that produces bytes.
// ----------------------------------------------------------------------------
module sfb_front import sfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // sample_count [15:0], sample_value [31:16]
    input  logic        i_s_tuser,   // req_type
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0] r_crc,  n_crc;
    logic [15:0] r_left, n_left;
    logic        r_open, n_open;

    logic        w_fire;
    logic        w_is_start;
    logic [15:0] w_cnt;
    logic [15:0] w_val;
    logic [15:0] w_crc_start;
    logic [15:0] w_crc_sample;

    assign o_s_tready   = !i_q_full;
    assign w_fire       = i_s_tvalid && !i_q_full;
    assign w_is_start   = (i_s_tuser == SFB_REQ_START);
    assign w_cnt        = i_s_tdata[15:0];
    assign w_val        = i_s_tdata[31:16];
    assign w_crc_start  = sfb_crc_word(SFB_CRC_INIT, w_cnt);
    assign w_crc_sample = sfb_crc_word(r_crc, w_val);

    always_comb begin
        n_crc  = r_crc;
        n_left = r_left;
        n_open = r_open;
        o_push = 1'b0;
        o_job  = '{is_hdr: w_is_start, with_crc: 1'b0, data: w_cnt, crc: w_crc_start};
        if (w_fire && w_is_start) begin
            o_push         = 1'b1;
            o_job.with_crc = (w_cnt == 16'h0000);
            n_crc          = w_crc_start;
            n_left         = w_cnt;
            n_open         = (w_cnt != 16'h0000);
        end else if (w_fire && r_open) begin
            o_push         = 1'b1;
            o_job.with_crc = (r_left == 16'h0001);
            o_job.data     = w_val;
            o_job.crc      = w_crc_sample;
            n_crc          = w_crc_sample;
            n_left         = r_left - 16'h0001;
            n_open         = (r_left != 16'h0001);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= SFB_CRC_INIT;
            r_left <= 16'h0000;
            r_open <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_left <= n_left;
            r_open <= n_open;
        end
    end

endmodule

/* sv/sfb_queue.sv */
// ----------------------------------------------------------------------------
// sfb_queue
// Small job queue between the request front end and the byte serializer.
// ----------------------------------------------------------------------------
module sfb_queue import sfb_pkg::*; #(
    parameter int DEPTH = SFB_Q_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_job                       i_job,
    output logic                       o_full,
    output logic                       o_valid,
    output t_job                       o_job,
    input  logic                       i_pop,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd];
    assign o_count   = r_count;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/sfb_back.sv */
// ----------------------------------------------------------------------------
// sfb_back
// Byte serializer: walks each queued job byte by byte into a registered
// output stage.
// ----------------------------------------------------------------------------
module sfb_back import sfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // out_byte
    output logic       o_m_tlast,   // run_last
    output logic       o_m_tuser    // frame_end
);

    localparam logic [2:0] IDX_PRE_A   = 3'd0;
    localparam logic [2:0] IDX_PRE_B   = 3'd1;
    localparam logic [2:0] IDX_DATA_LO = 3'd2;
    localparam logic [2:0] IDX_DATA_HI = 3'd3;
    localparam logic [2:0] IDX_CRC_LO  = 3'd4;
    localparam logic [2:0] IDX_CRC_HI  = 3'd5;

    t_job       r_job;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic       r_out_end;

    logic       w_can_load;
    logic       w_issue;
    logic       w_is_last;
    logic       w_take;
    logic [2:0] w_last_idx;
    logic [7:0] w_byte;

    assign w_last_idx = r_job.with_crc ? IDX_CRC_HI : IDX_DATA_HI;
    assign w_can_load = !r_out_valid || i_m_tready;
    assign w_issue    = w_can_load && r_busy;
    assign w_is_last  = (r_idx == w_last_idx);
    assign w_take     = i_q_valid && (!r_busy || (w_issue && w_is_last));
    assign o_pop      = w_take;

    always_comb begin
        unique case (r_idx)
            IDX_PRE_A:   w_byte = SFB_PRE_FIRST;
            IDX_PRE_B:   w_byte = SFB_PRE_SECOND;
            IDX_DATA_LO: w_byte = r_job.data[7:0];
            IDX_DATA_HI: w_byte = r_job.data[15:8];
            IDX_CRC_LO:  w_byte = r_job.crc[7:0];
            IDX_CRC_HI:  w_byte = r_job.crc[15:8];
            default:     w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= i_q_job;
        end
        if (w_issue) begin
            r_out_data <= w_byte;
            r_out_last <= w_is_last;
            r_out_end  <= (r_idx == IDX_CRC_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= IDX_PRE_A;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
                r_idx  <= i_q_job.is_hdr ? IDX_PRE_A : IDX_DATA_LO;
            end else if (w_issue && w_is_last) begin
                r_busy <= 1'b0;
            end else if (w_issue) begin
                r_idx <= r_idx + 3'd1;
            end
            if (w_issue) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;

endmodule

/* sv/sample_frame_builder_crc16.sv */
// ----------------------------------------------------------------------------
// sample_frame_builder_crc16
// Frames 16-bit samples into a byte stream: preamble, count, samples and a
// crc-16/ccitt-false trailer over count and samples.
//
//   channel  dir  handshake                    payload
//   s        in   i_s_tvalid / o_s_tready      tdata: count, sample; tuser: req_type
//   m        out  o_m_tvalid / i_m_tready      tdata: byte; tlast: run_last; tuser: frame_end
//
// one output byte per cycle from the serializer while i_m_tready does not stall it:
// a sample gives 2 bytes, 4 with the trailer; a start gives 4 bytes, 6 with a zero count
// requests are taken one per cycle while the job queue has room
// input reaches the first byte via the queue, job and output registers; samples outside
// an open frame are taken and dropped; reset is synchronous, active low, and opens no frame
// ----------------------------------------------------------------------------
module sample_frame_builder_crc16 import sfb_pkg::*; #(
    parameter int Q_DEPTH = SFB_Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // sample_count [15:0], sample_value [31:16]
    input  logic        i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tlast,   // run_last
    output logic        o_m_tuser    // frame_end
);

    localparam int CW = $clog2(Q_DEPTH + 1);

    logic          w_push;
    logic          w_full;
    t_job          w_push_job;
    logic          w_q_valid;
    t_job          w_q_job;
    logic          w_pop;
    logic [CW-1:0] w_count;

    sfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    sfb_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_pop),
        .o_count (w_count)
    );

    sfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_job    (w_q_job),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("frame end byte without run end");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(Q_DEPTH))
        else $error("queue count out of range");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");
`endif

endmodule
